FILE: rtl/rqs_pkg.sv
// Shared types, constants and helper functions of the ring queue with search.
package rqs_pkg;

  localparam int DEPTH       = 64;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 7;
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;

  // Result word layout, lowest bit first: data, slot, count, is_empty, is_full.
  localparam int OUT_DATA_LSB  = 0;
  localparam int OUT_SLOT_LSB  = OUT_DATA_LSB + DATA_W;
  localparam int OUT_COUNT_LSB = OUT_SLOT_LSB + PTR_W;
  localparam int OUT_EMPTY_BIT = OUT_COUNT_LSB + CNT_W;
  localparam int OUT_FULL_BIT  = OUT_EMPTY_BIT + 1;
  localparam int OUT_RAW_W     = OUT_FULL_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ  = 3'd0,
    FN_DEQ  = 3'd1,
    FN_PEEK = 3'd2,
    FN_SRCH = 3'd3,
    FN_CLR  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_READ,
    SQ_SCAN
  } seq_state_t;

  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [PTR_W-1:0]  slot;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
  } res_t;

  // A capacity of zero behaves as one, anything above the store size as the store size.
  function automatic logic [CNT_W-1:0] cap_eff(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] r;
    if (cap == '0) begin
      r = CNT_W'(1);
    end else if (int'(cap) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(cap);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

FILE: rtl/rqs_mem.sv
// Word store of the queue: one write port and one registered read port.
module rqs_mem
  import rqs_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read data holds its value between reads.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: rtl/rqs_ctrl.sv
// Sequencer with pointers, count and the shared word comparator of the search.
module rqs_ctrl
  import rqs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_value,
  input  logic              out_free,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] rd_data,
  output logic              res_load,
  output res_t              res
);

  seq_state_t        state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [PTR_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]  cap;
  logic              accept;
  logic              match;
  func_t             func;

  assign cap      = cap_eff(cap_r);
  assign in_ready = (state_r == SQ_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign func     = func_t'(in_func);
  assign match    = (rd_data == key_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          case (func) inside
            FN_DEQ, FN_PEEK: if (held_r != '0) state_nxt = SQ_READ;
            FN_SRCH:         if (held_r != '0) state_nxt = SQ_SCAN;
            default:         state_nxt = SQ_IDLE;
          endcase
        end
      end
      SQ_READ: state_nxt = SQ_IDLE;
      SQ_SCAN: begin
        if (match || remain_r == CNT_W'(1)) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    cap_nxt     = cap_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    held_nxt    = held_r;
    cmp_idx_nxt = cmp_idx_r;
    remain_nxt  = remain_r;
    key_nxt     = key_r;
    mem_req     = '0;
    res_load    = 1'b0;
    res.status  = ST_OK;
    res.data    = '0;
    res.slot    = '0;

    unique case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          case (func) inside
            FN_ENQ: begin
              res_load = 1'b1;
              if (held_r >= cap) begin
                res.status = ST_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = tail_r;
                mem_req.wr_data = in_value;
                tail_nxt        = advance(tail_r, cap);
                held_nxt        = held_r + CNT_W'(1);
              end
            end
            FN_DEQ, FN_PEEK: begin
              if (held_r == '0) begin
                res_load   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = head_r;
                if (func == FN_DEQ) begin
                  head_nxt = advance(head_r, cap);
                  held_nxt = held_r - CNT_W'(1);
                end
              end
            end
            FN_SRCH: begin
              if (held_r == '0) begin
                res_load   = 1'b1;
                res.status = ST_NOTFOUND;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = head_r;
                cmp_idx_nxt     = head_r;
                remain_nxt      = held_r;
                key_nxt         = in_value;
              end
            end
            FN_CLR: begin
              res_load = 1'b1;
              head_nxt = '0;
              tail_nxt = '0;
              held_nxt = '0;
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      SQ_READ: begin
        res_load = 1'b1;
        res.data = rd_data;
      end
      SQ_SCAN: begin
        // One stored word is compared per cycle while the next read is issued.
        if (match) begin
          res_load = 1'b1;
          res.slot = cmp_idx_r;
        end else if (remain_r == CNT_W'(1)) begin
          res_load   = 1'b1;
          res.status = ST_NOTFOUND;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = advance(cmp_idx_r, cap);
          cmp_idx_nxt     = advance(cmp_idx_r, cap);
          remain_nxt      = remain_r - CNT_W'(1);
        end
      end
      default: res_load = 1'b0;
    endcase

    if (cfg_wr_en) begin
      cap_nxt  = cfg_wr_data;
      head_nxt = '0;
      tail_nxt = '0;
      held_nxt = '0;
    end

    res.count    = held_nxt;
    res.is_empty = (held_nxt == '0);
    res.is_full  = (held_nxt == cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      cap_r   <= CAP_W'(DEPTH);
      head_r  <= '0;
      tail_r  <= '0;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    remain_r  <= remain_nxt;
    key_r     <= key_nxt;
  end

endmodule

FILE: rtl/ring_queue_with_search_unit.sv
// Top level of the ring queue with search: sequencer, word store and result register.
//
//   channel  direction  handshake           payload
//   in_      slave      in_tvalid/tready    tuser = func, tdata = value
//   out_     master     out_tvalid/tready   tuser = status, tdata = data..is_full
//   cfg_     write      cfg_wr_en           cfg_wr_data = capacity
//
// Enqueue, clear, and requests refused as full or empty load the result from the idle
// state; dequeue and peek pass through SQ_READ, since the store's read port is registered.
// A search compares the entries in turn from the head in SQ_SCAN, up to count of them,
// paced by the single comparator behind the store's read port; it stops at a match.
// Reset is synchronous; the store needs no clearing pass, so requests are taken at once.
// A result waiting on out_tready holds its register and blocks the next request.
module ring_queue_with_search_unit
  import rqs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // value
  input  logic [FUNC_W-1:0]      in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data, slot, count, is_empty, is_full, zero pad
  output logic [STATUS_W-1:0]    out_tuser   // status
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;
  logic              res_load;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r;
  logic              out_free;

  assign out_free = !out_valid_r || out_tready;

  rqs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tuser),
    .in_value    (in_tdata),
    .out_free    (out_free),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .res_load    (res_load),
    .res         (res)
  );

  rqs_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;

  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_SLOT_LSB-1:OUT_DATA_LSB]   = out_res_r.data;
    out_tdata[OUT_COUNT_LSB-1:OUT_SLOT_LSB]  = out_res_r.slot;
    out_tdata[OUT_EMPTY_BIT-1:OUT_COUNT_LSB] = out_res_r.count;
    out_tdata[OUT_EMPTY_BIT]                 = out_res_r.is_empty;
    out_tdata[OUT_FULL_BIT]                  = out_res_r.is_full;
  end

endmodule

FILE: rtl/rqs_checker.sv
// Port-level checks on the ring queue with search, bound to its top level.
module rqs_checker
  import rqs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while a result is stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_EMPTY_BIT] == (out_tdata[OUT_EMPTY_BIT-1:OUT_COUNT_LSB] == '0))
    else $error("empty flag disagrees with count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> out_tdata[OUT_FULL_BIT])
    else $error("full status without full flag");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY
      |-> out_tdata[OUT_SLOT_LSB-1:OUT_DATA_LSB] == '0 && out_tdata[OUT_EMPTY_BIT])
    else $error("empty status with data or non-empty queue");

endmodule

bind ring_queue_with_search_unit rqs_checker u_rqs_checker (.*);

FILE: sim/ring_queue_with_search_unit_tb.sv
// Self-checking testbench for the ring queue with search: directed and random requests.
module ring_queue_with_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rqs_pkg::*;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [PTR_W-1:0]  slot;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
  } queue_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CAP_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata;
  logic [FUNC_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // Shadow copy of the queue, updated as each request is accepted.
  logic [DATA_W-1:0] shadow_store [DEPTH];
  int                shadow_head;
  int                shadow_tail;
  int                shadow_held;
  logic [CAP_W-1:0]  shadow_cap;

  queue_reply_t responses_due [$];
  int           mismatches = 0;
  bit           hurry = 1'b0;

  ring_queue_with_search_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic int usable_slots(input logic [CAP_W-1:0] c);
    if (c == '0) begin
      return 1;
    end
    if (int'(c) > DEPTH) begin
      return DEPTH;
    end
    return int'(c);
  endfunction

  function automatic int step_ptr(input int p, input int lim);
    return (p + 1 >= lim) ? 0 : p + 1;
  endfunction

  function automatic void empty_shadow();
    shadow_head = 0;
    shadow_tail = 0;
    shadow_held = 0;
  endfunction

  function automatic queue_reply_t apply_queue_op(input logic [FUNC_W-1:0] fn,
                                                  input logic [DATA_W-1:0] word);
    queue_reply_t r;
    int lim;
    int idx;
    int i;
    lim = usable_slots(shadow_cap);
    r.status = ST_OK;
    r.data = '0;
    r.slot = '0;
    case (fn)
      FN_ENQ: begin
        if (shadow_held >= lim) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[shadow_tail] = word;
          shadow_tail = step_ptr(shadow_tail, lim);
          shadow_held++;
        end
      end
      FN_DEQ: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_store[shadow_head];
          shadow_head = step_ptr(shadow_head, lim);
          shadow_held--;
        end
      end
      FN_PEEK: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = shadow_store[shadow_head];
        end
      end
      FN_SRCH: begin
        // Walk from the oldest entry; the first equal word wins.
        r.status = ST_NOTFOUND;
        idx = shadow_head;
        for (i = 0; i < shadow_held; i++) begin
          if (shadow_store[idx] == word) begin
            r.status = ST_OK;
            r.slot = PTR_W'(idx);
            break;
          end
          idx = step_ptr(idx, lim);
        end
      end
      FN_CLR: begin
        empty_shadow();
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(shadow_held);
    r.is_empty = (shadow_held == 0);
    r.is_full = (shadow_held == lim);
    return r;
  endfunction

  function automatic int idle_cycles();
    return hurry ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic log_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_reply(input logic [STATUS_W-1:0] st,
                             input logic [OUT_TDATA_W-1:0] word);
    queue_reply_t want;
    if (responses_due.size() == 0) begin
      log_mismatch("result with no request outstanding");
    end else begin
      want = responses_due.pop_front();
      if (st != want.status) begin
        log_mismatch($sformatf("status got %0d, expected %0d", st, want.status));
      end
      if (word[OUT_DATA_LSB +: DATA_W] != want.data) begin
        log_mismatch($sformatf("data got %h, expected %h",
                               word[OUT_DATA_LSB +: DATA_W], want.data));
      end
      if (word[OUT_SLOT_LSB +: PTR_W] != want.slot) begin
        log_mismatch($sformatf("slot got %0d, expected %0d",
                               word[OUT_SLOT_LSB +: PTR_W], want.slot));
      end
      if (word[OUT_COUNT_LSB +: CNT_W] != want.count) begin
        log_mismatch($sformatf("count got %0d, expected %0d",
                               word[OUT_COUNT_LSB +: CNT_W], want.count));
      end
      if (word[OUT_EMPTY_BIT] !== want.is_empty) begin
        log_mismatch($sformatf("is_empty got %b, expected %b",
                               word[OUT_EMPTY_BIT], want.is_empty));
      end
      if (word[OUT_FULL_BIT] !== want.is_full) begin
        log_mismatch($sformatf("is_full got %b, expected %b",
                               word[OUT_FULL_BIT], want.is_full));
      end
    end
  endtask

  // Receiving side: stalls at random before each result, then checks it.
  initial begin : result_checker
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      check_reply(out_tuser, out_tdata);
    end
  end

  // The request is left raised on return so that a back-to-back request keeps it high.
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] word);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    responses_due.push_back(apply_queue_op(fn, word));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_for_results();
    repeat (3) @(posedge clk);
    cfg_wr_data <= c;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_cap = c;
    empty_shadow();
  endtask

  // A share of pool_pct percent of the words comes from a small pool so that searches find matches.
  function automatic logic [DATA_W-1:0] pick_word(input int pool_pct);
    logic [DATA_W-1:0] pool [8];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 32'h0000_0002, 32'h5555_5555, 32'hAAAA_AAAA};
    if ($urandom_range(0, 99) < pool_pct) begin
      return pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  task automatic test_empty_and_extremes();
    send_request(FN_PEEK, 32'h1234_5678);
    send_request(FN_DEQ, 32'h0);
    send_request(FN_SRCH, 32'h0);
    send_request(FN_ENQ, 32'h8000_0000);
    send_request(FN_ENQ, 32'h7FFF_FFFF);
    send_request(FN_ENQ, 32'hFFFF_FFFF);
    send_request(FN_ENQ, 32'h0000_0000);
    send_request(FN_SRCH, 32'h7FFF_FFFF);
    send_request(FN_SRCH, 32'h1234_5678);
    send_request(FN_PEEK, 32'h0);
    send_request(FN_DEQ, 32'h0);
    // Unused operation codes leave the queue alone.
    send_request(FUNC_W'(5), 32'hFFFF_FFFF);
    send_request(FUNC_W'(6), 32'h0);
    send_request(FUNC_W'(7), 32'h7FFF_FFFF);
    send_request(FN_CLR, 32'h0);
    send_request(FN_DEQ, 32'h0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(CAP_W'(2));
    send_request(FN_ENQ, 32'h0000_00A1);
    send_request(FN_ENQ, 32'h0000_00B2);
    send_request(FN_ENQ, 32'h0000_00C3);
    send_request(FN_SRCH, 32'h0000_00B2);
    send_request(FN_DEQ, 32'h0);
    // The tail wraps to slot zero, so the match lies behind the head.
    send_request(FN_ENQ, 32'h0000_00A1);
    send_request(FN_SRCH, 32'h0000_00A1);
    send_request(FN_DEQ, 32'h0);
    send_request(FN_DEQ, 32'h0);
    send_request(FN_DEQ, 32'h0);
    // A capacity of zero behaves as one slot.
    set_capacity(CAP_W'(0));
    send_request(FN_ENQ, 32'hDEAD_BEEF);
    send_request(FN_ENQ, 32'h0BAD_F00D);
    send_request(FN_PEEK, 32'h0);
  endtask

  task automatic run_random_phase(input int n, input int enq_w, input int deq_w,
                                  input int clr_w);
    int total;
    int r;
    int k;
    logic [FUNC_W-1:0] fn;
    total = enq_w + deq_w + 10 + 15 + clr_w + 2;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        hurry = !hurry;
      end
      if ($urandom_range(0, 59) == 0) begin
        wait_for_results();
      end
      r = $urandom_range(0, total - 1);
      if (r < enq_w) begin
        fn = FN_ENQ;
      end else if (r < enq_w + deq_w) begin
        fn = FN_DEQ;
      end else if (r < enq_w + deq_w + 10) begin
        fn = FN_PEEK;
      end else if (r < enq_w + deq_w + 25) begin
        fn = FN_SRCH;
      end else if (r < enq_w + deq_w + 25 + clr_w) begin
        fn = FN_CLR;
      end else begin
        fn = FUNC_W'($urandom_range(5, 7));
      end
      send_request(fn, pick_word((fn == FN_SRCH) ? 70 : 50));
    end
  endtask

  task automatic test_random_traffic();
    // Above the store size the capacity saturates; enqueue-heavy to reach full.
    set_capacity(CAP_W'(127));
    run_random_phase(230, 55, 10, 0);
    set_capacity(CAP_W'(5));
    run_random_phase(200, 30, 30, 2);
    set_capacity(CAP_W'(0));
    run_random_phase(80, 30, 30, 2);
    set_capacity(CAP_W'(64));
    run_random_phase(120, 55, 10, 0);
    run_random_phase(60, 5, 55, 0);
    set_capacity(CAP_W'(33));
    run_random_phase(150, 35, 30, 1);
    set_capacity(CAP_W'(1));
    run_random_phase(40, 30, 30, 2);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    shadow_cap = CAP_W'(64);
    empty_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_extremes();
    test_capacity_limits();
    test_random_traffic();
    wait_for_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && responses_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: ring_queue_with_search_unit.f
rtl/rqs_pkg.sv
rtl/rqs_mem.sv
rtl/rqs_ctrl.sv
rtl/ring_queue_with_search_unit.sv
rtl/rqs_checker.sv
sim/ring_queue_with_search_unit_tb.sv
